[design/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and bit-mapping functions for the Hamming SEC codec.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

   localparam int WORD_W            = 63;
   localparam int SYN_W             = 6;
   localparam int CSR_W             = 6;
   localparam int DEF_MAX_DATA_BITS = 57;
   localparam logic [CSR_W-1:0] RESET_DATA_BITS = CSR_W'(4);

   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic [WORD_W-1:0] corrected_code;
      logic [SYN_W-1:0]  syndrome;
      logic              bit_corrected;
      logic              uncorrectable;
   } rsp_type;

   typedef struct packed {
      logic [SYN_W-1:0]  code_len;
      logic [WORD_W-1:0] data_mask;
      logic [WORD_W-1:0] code_mask;
   } cfg_type;

   function automatic logic is_pow2(input int pos);
      return (pos & (pos - 1)) == 0;
   endfunction

   // data bit j goes to the j-th position that is not a power of two
   function automatic logic [WORD_W-1:0] spread(input logic [WORD_W-1:0] data);
      logic [WORD_W-1:0] code;
      int                j;
      code = '0;
      j    = 0;
      for (int pos = 1; pos <= WORD_W; pos++) begin
         if (!is_pow2(pos)) begin
            code[pos-1] = data[j];
            j++;
         end
      end
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] extract(input logic [WORD_W-1:0] code);
      logic [WORD_W-1:0] data;
      int                j;
      data = '0;
      j    = 0;
      for (int pos = 1; pos <= WORD_W; pos++) begin
         if (!is_pow2(pos)) begin
            data[j] = code[pos-1];
            j++;
         end
      end
      return data;
   endfunction

   function automatic logic [SYN_W-1:0] syndrome_of(input logic [WORD_W-1:0] code);
      logic [SYN_W-1:0] syn;
      syn = '0;
      for (int pos = 1; pos <= WORD_W; pos++) begin
         if (code[pos-1]) begin
            syn = syn ^ SYN_W'(pos);
         end
      end
      return syn;
   endfunction

endpackage

`default_nettype wire

[design/hsc_cfg.sv]
// ----------------------------------------------------------------------------
// hsc_cfg
// Data width register with the derived code length and bit masks.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_cfg
   import hsc_pkg::*;
#(
   parameter int MAX_DATA_BITS = DEF_MAX_DATA_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   function automatic cfg_type derive(input logic [CSR_W-1:0] raw);
      cfg_type          c;
      logic [CSR_W-1:0] k;
      logic [CSR_W-1:0] r;
      k = (raw > CSR_W'(MAX_DATA_BITS)) ? CSR_W'(MAX_DATA_BITS) : raw;
      r = '0;
      for (int p = 0; p <= SYN_W; p++) begin
         if ((1 << p) < (int'(k) + p + 1)) begin
            r = CSR_W'(p + 1);
         end
      end
      c.code_len = SYN_W'(k + r);
      for (int i = 0; i < WORD_W; i++) begin
         c.data_mask[i] = (i < int'(k));
         c.code_mask[i] = (i < int'(c.code_len));
      end
      return c;
   endfunction

   assign csr_ready = 1'b1;
   assign cfg_in    = derive(csr_data);
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= derive(RESET_DATA_BITS);
      end else if (csr_valid) begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/hamming_sec_codec.sv]
// ----------------------------------------------------------------------------
// hamming_sec_codec
// Hamming single-error-correcting encoder/decoder with a programmable data
// width, in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_type (action, word_in)
// rsp_      out        rsp_valid / rsp_ready   rsp_type (result, code, flags)
// csr_      in         csr_valid / csr_ready   data width k, 6 bits
//
// One request per cycle while the result channel is not stalled; a request passes
// through the stages place/mask, syndrome tree and correct/extract, each
// registered, before its result is valid on the result channel.
// Synchronous reset empties the pipeline and restores the data width to 4.
// A stalled output holds; upstream stages keep filling bubbles until full.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_codec
   import hsc_pkg::*;
#(
   parameter int MAX_DATA_BITS = DEF_MAX_DATA_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_data
);

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] code;
   } place_type;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] code;
      logic [SYN_W-1:0]  syn;
   } syn_type;

   cfg_type   cfg;

   logic      s1_valid_ff;
   logic      s2_valid_ff;
   logic      s3_valid_ff;
   logic      s1_ready;
   logic      s2_ready;
   logic      s3_ready;
   place_type s1_ff;
   place_type s1_in;
   syn_type   s2_ff;
   syn_type   s2_in;
   rsp_type   s3_ff;
   rsp_type   s3_in;

   hsc_cfg #(
      .MAX_DATA_BITS(MAX_DATA_BITS)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .cfg      (cfg)
   );

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_ff;

   always_comb begin
      s1_in.action = req_data.action;
      if (req_data.action == ACT_DECODE) begin
         s1_in.code = req_data.word_in & cfg.code_mask;
      end else begin
         s1_in.code = spread(req_data.word_in & cfg.data_mask);
      end
   end

   always_comb begin
      s2_in.action = s1_ff.action;
      s2_in.code   = s1_ff.code;
      s2_in.syn    = syndrome_of(s1_ff.code);
   end

   always_comb begin
      logic [WORD_W-1:0] code;
      logic              fix;
      code  = s2_ff.code;
      fix   = 1'b0;
      s3_in = '0;
      if (s2_ff.action == ACT_DECODE) begin
         fix = (s2_ff.syn != '0) && (s2_ff.syn <= cfg.code_len);
         for (int i = 0; i < WORD_W; i++) begin
            if (fix && (s2_ff.syn == SYN_W'(i + 1))) begin
               code[i] = !code[i];
            end
         end
         s3_in.result_word    = extract(code);
         s3_in.corrected_code = code;
         s3_in.syndrome       = s2_ff.syn;
         s3_in.bit_corrected  = fix;
         s3_in.uncorrectable  = (s2_ff.syn != '0) && !fix;
      end else begin
         for (int p = 0; p < SYN_W; p++) begin
            if (s2_ff.syn[p]) begin
               code[(1 << p) - 1] = 1'b1;
            end
         end
         s3_in.result_word    = code;
         s3_in.corrected_code = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

[design/hsc_checker.sv]
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks on the result channel of the Hamming SEC codec.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_checker
   import hsc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled request changed or dropped");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.bit_corrected && rsp_data.uncorrectable))
      else $error("corrected and uncorrectable both set");

   a_syn_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.syndrome != '0) ==
                     (rsp_data.bit_corrected || rsp_data.uncorrectable)))
      else $error("syndrome and flags disagree");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hamming_sec_codec hsc_checker u_hsc_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hamming_sec_codec. Encode and decode requests are pushed into
// a queue that a clocked driver sends on the request channel. Each accepted
// request is run through a local SEC code model at the data width held by the
// register, and every response is checked field by field in order. Directed
// tests and phases step through data widths (reset value, empty code, one bit,
// the maximum, saturation, random) and sender and receiver idling patterns.
// ----------------------------------------------------------------------------

module tb_top;
   import hsc_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int MAX_K        = DEF_MAX_DATA_BITS;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int PHASE_ITEMS  = 62;
   localparam int PHASES       = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data  = '0;

   req_type          request_q[$];
   rsp_type          outcome_q[$];
   rsp_type          due;
   logic [CSR_W-1:0] width_now      = RESET_DATA_BITS;
   logic             req_fire       = 1'b0;
   logic             csr_fire       = 1'b0;
   logic             hold_req       = 1'b0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               errors         = 0;
   int               cycle_count    = 0;

   hamming_sec_codec #(
      .MAX_DATA_BITS(MAX_K)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   function automatic int code_length(input logic [CSR_W-1:0] width);
      int k;
      int r;
      k = (int'(width) > MAX_K) ? MAX_K : int'(width);
      r = 0;
      while ((1 << r) < k + r + 1) begin
         r++;
      end
      return k + r;
   endfunction

   function automatic logic [SYN_W-1:0] position_xor(input logic [WORD_W-1:0] code,
                                                     input int n);
      logic [SYN_W-1:0] acc;
      acc = '0;
      for (int pos = 1; pos <= n; pos++) begin
         if (code[pos-1]) begin
            acc = acc ^ SYN_W'(pos);
         end
      end
      return acc;
   endfunction

   function automatic rsp_type sec_outcome(input req_type rq, input logic [CSR_W-1:0] width);
      rsp_type           rs;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] data;
      logic [SYN_W-1:0]  syn;
      int                n;
      int                j;
      n    = code_length(width);
      rs   = '0;
      code = '0;
      data = '0;
      j    = 0;
      if (rq.action == ACT_ENCODE) begin
         for (int pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               code[pos-1] = rq.word_in[j];
               j++;
            end
         end
         syn = position_xor(code, n);
         for (int b = 0; b < SYN_W; b++) begin
            if (syn[b]) begin
               code[(1 << b) - 1] = 1'b1;
            end
         end
         rs.result_word    = code;
         rs.corrected_code = code;
      end else begin
         for (int pos = 1; pos <= n; pos++) begin
            code[pos-1] = rq.word_in[pos-1];
         end
         syn = position_xor(code, n);
         if (syn != '0) begin
            if (int'(syn) <= n) begin
               code[int'(syn) - 1] = ~code[int'(syn) - 1];
               rs.bit_corrected    = 1'b1;
            end else begin
               rs.uncorrectable = 1'b1;
            end
         end
         for (int pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               data[j] = code[pos-1];
               j++;
            end
         end
         rs.result_word    = data;
         rs.corrected_code = code;
         rs.syndrome       = syn;
      end
      return rs;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      return WORD_W'({$urandom, $urandom});
   endfunction

   function automatic logic [WORD_W-1:0] codeword_of(input logic [WORD_W-1:0] data,
                                                     input logic [CSR_W-1:0] width);
      req_type rq;
      rsp_type rs;
      rq.action  = ACT_ENCODE;
      rq.word_in = data;
      rs         = sec_outcome(rq, width);
      return rs.result_word;
   endfunction

   // encode requests, valid codewords with zero, one or two flipped bits, or raw noise
   function automatic req_type shaped_request(input logic [CSR_W-1:0] width);
      req_type           rq;
      logic [WORD_W-1:0] above;
      int                n;
      int                pick;
      int                flips;
      int                pos;
      n     = code_length(width);
      pick  = $urandom_range(99);
      above = random_word();
      for (int b = 0; b < n; b++) begin
         above[b] = 1'b0;
      end
      rq.action  = ACT_DECODE;
      rq.word_in = random_word();
      if (pick < 40) begin
         rq.action = ACT_ENCODE;
      end else if (pick < 85) begin
         rq.word_in = codeword_of(random_word(), width);
         if ($urandom_range(3) == 0) begin
            rq.word_in = rq.word_in | above;
         end
         flips = $urandom_range(9);
         flips = (flips < 4) ? 0 : (flips < 8) ? 1 : 2;
         if (n > 0) begin
            repeat (flips) begin
               pos             = $urandom_range(n - 1);
               rq.word_in[pos] = ~rq.word_in[pos];
            end
         end
      end
      return rq;
   endfunction

   task automatic push(input logic act, input logic [WORD_W-1:0] word);
      req_type rq;
      rq.action  = act;
      rq.word_in = word;
      request_q.push_back(rq);
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         errors = errors + 1;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
   endtask

   task automatic write_width(input logic [CSR_W-1:0] width);
      wait_drained();
      csr_data  <= width;
      csr_valid <= 1'b1;
      do @(negedge clock);
      while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   // driver: hold the request until accepted, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (request_q.size() != 0 && !hold_req && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= request_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire    <= req_valid && req_ready;
      csr_fire    <= csr_valid && csr_ready;
      if (reset) begin
         width_now <= RESET_DATA_BITS;
      end else begin
         if (csr_valid && csr_ready) begin
            width_now <= csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("response with no request outstanding");
               errors = errors + 1;
            end else begin
               due = outcome_q.pop_front();
               check_field("result_word", due.result_word, rsp_data.result_word);
               check_field("corrected_code", due.corrected_code, rsp_data.corrected_code);
               check_field("syndrome", WORD_W'(due.syndrome), WORD_W'(rsp_data.syndrome));
               check_field("bit_corrected", WORD_W'(due.bit_corrected),
                           WORD_W'(rsp_data.bit_corrected));
               check_field("uncorrectable", WORD_W'(due.uncorrectable),
                           WORD_W'(rsp_data.uncorrectable));
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(sec_outcome(req_data, width_now));
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      logic [CSR_W-1:0]  width_list [PHASES];
      int                send_pct [4];
      int                recv_pct [4];
      logic [WORD_W-1:0] cw;
      width_list = '{6'd57, 6'd11, 6'd1, 6'd63, 6'd26, 6'd0, 6'd2, 6'd0};
      width_list[5] = CSR_W'($urandom_range(63));
      width_list[7] = CSR_W'($urandom_range(63, 3));
      send_pct = '{0, 71, 0, 13};
      recv_pct = '{0, 0, 71, 13};

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset width: seven-bit code
      cw = codeword_of(63'hB, RESET_DATA_BITS);
      push(ACT_ENCODE, '0);
      push(ACT_ENCODE, '1);
      push(ACT_ENCODE, 63'h5);
      push(ACT_DECODE, '0);
      push(ACT_DECODE, '1);
      push(ACT_DECODE, cw);
      push(ACT_DECODE, cw ^ 63'h1);
      push(ACT_DECODE, cw ^ 63'h8);
      push(ACT_DECODE, cw ^ 63'h40);
      push(ACT_DECODE, cw | ~63'h7F);

      // five-bit code: syndromes above the code length
      write_width(6'd2);
      push(ACT_DECODE, 63'h0A);
      push(ACT_DECODE, 63'h0C);
      push(ACT_ENCODE, '1);

      // empty code
      write_width(6'd0);
      push(ACT_ENCODE, '1);
      push(ACT_DECODE, '1);

      // saturated width, full 63-bit code
      write_width(6'd63);
      push(ACT_ENCODE, '1);
      push(ACT_DECODE, '1);
      push(ACT_DECODE, {1'b1, 62'b0});

      write_width(6'd1);
      push(ACT_DECODE, 63'h7);
      push(ACT_ENCODE, 63'h1);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_width(width_list[phase]);
         @(posedge clock);
         send_idle_pct  <= send_pct[phase % 4];
         recv_stall_pct <= recv_pct[phase % 4];
         repeat (PHASE_ITEMS) begin
            request_q.push_back(shaped_request(width_list[phase]));
         end
         if (phase == 1) begin
            do @(negedge clock);
            while (request_q.size() > PHASE_ITEMS / 2);
            hold_req <= 1'b1;
            do @(negedge clock);
            while (req_valid || outcome_q.size() != 0);
            hold_req <= 1'b0;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $error("%0d responses never arrived", outcome_q.size());
         errors = errors + 1;
      end
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
